/* design/npm_pkg.sv */
// Shared constants, payload types and the nim product table for the nim multiplier.
package npm_pkg;

  localparam int OPERAND_BITS = 30;
  localparam int FIELD_BITS = 32;
  localparam int GROUP_SIZE = 5;
  localparam int GROUPS = (OPERAND_BITS + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic [FIELD_BITS-1:0][FIELD_BITS-1:0][FIELD_BITS-1:0] nim_table_t;

  typedef struct packed {
    logic [OPERAND_BITS-1:0]                 left;
    logic [OPERAND_BITS-1:0][FIELD_BITS-1:0] rows;
  } row_word_t;

  typedef logic [GROUPS-1:0][FIELD_BITS-1:0] group_word_t;

  // Entry [i][j] is the nim product of 2^i and 2^j. Entries are built in order of the
  // larger index, so every entry used on the right side is already filled in.
  function automatic nim_table_t nim_table_build();
    nim_table_t      t;
    int              c;
    int              k;
    int              f;
    int              msk;
    int              hsh;
    int              li;
    int              lj;
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic [FIELD_BITS-1:0] v;
    t = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      for (int j = 0; j <= i; j++) begin
        c = i & j;
        if (c == 0) begin
          v = FIELD_BITS'(1) << (i | j);
        end else begin
          k = 0;
          for (int b = 0; b < 5; b++) begin
            if (((c >> b) & 1) == 1) begin
              k = b;
            end
          end
          f = 1 << k;
          msk = (f << 1) - 1;
          hsh = (i | j) & ~msk;
          li = (i & msk) ^ f;
          lj = (j & msk) ^ f;
          x = t[li][lj];
          y = x << f;
          for (int b = 0; b < FIELD_BITS; b++) begin
            if (x[b]) begin
              y = y ^ t[b][f-1];
            end
          end
          v = y << hsh;
        end
        t[i][j] = v;
        t[j][i] = v;
      end
    end
    return t;
  endfunction

  localparam nim_table_t NIM_TABLE = nim_table_build();

endpackage

/* design/npm_in_if.sv */
// Operand channel: valid, ready and one pair of nimber factors.
interface npm_in_if;
  logic                             valid;
  logic                             ready;
  logic [npm_pkg::OPERAND_BITS-1:0] left_operand;
  logic [npm_pkg::OPERAND_BITS-1:0] right_operand;

  modport source (output valid, output left_operand, output right_operand, input ready);
  modport sink (input valid, input left_operand, input right_operand, output ready);
endinterface

/* design/npm_out_if.sv */
// Result channel: valid, ready and one nim product.
interface npm_out_if;
  logic                           valid;
  logic                           ready;
  logic [npm_pkg::FIELD_BITS-1:0] product;

  modport source (output valid, output product, input ready);
  modport sink (input valid, input product, output ready);
endinterface

/* design/npm_row_stage.sv */
// First stage: the right factor times each power of two of the left factor.
module npm_row_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [npm_pkg::OPERAND_BITS-1:0] left,
  input  logic [npm_pkg::OPERAND_BITS-1:0] right,
  output logic                             out_valid,
  input  logic                             out_ready,
  output npm_pkg::row_word_t               out_word
);
  import npm_pkg::*;

  row_word_t word_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    word_next.left = left;
    for (int i = 0; i < OPERAND_BITS; i++) begin
      word_next.rows[i] = '0;
      for (int j = 0; j < OPERAND_BITS; j++) begin
        if (right[j]) begin
          word_next.rows[i] = word_next.rows[i] ^ NIM_TABLE[i][j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

/* design/npm_group_stage.sv */
// Second stage: selects rows by the left factor bits and folds them in groups.
module npm_group_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  npm_pkg::row_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output npm_pkg::group_word_t out_word
);
  import npm_pkg::*;

  group_word_t word_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      word_next[g] = '0;
      for (int m = 0; m < GROUP_SIZE; m++) begin
        if (g * GROUP_SIZE + m < OPERAND_BITS) begin
          if (in_word.left[g * GROUP_SIZE + m]) begin
            word_next[g] = word_next[g] ^ in_word.rows[g * GROUP_SIZE + m];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

/* design/npm_sum_stage.sv */
// Third stage: folds the group sums into the product and holds it for the sink.
module npm_sum_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  npm_pkg::group_word_t           in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [npm_pkg::FIELD_BITS-1:0] product
);
  import npm_pkg::*;

  logic [FIELD_BITS-1:0] product_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    product_next = '0;
    for (int g = 0; g < GROUPS; g++) begin
      product_next = product_next ^ in_word[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      product <= product_next;
    end
  end

endmodule

/* design/nim_product_multiplier_top.sv */
// Top level of the pipelined nim product multiplier.
//
//   channel    direction  payload
//   operands   in         left_operand, right_operand
//   result     out        product
//
// One operand word is accepted every cycle while the result sink keeps up; its product
// passes through the row, group and sum register stages in that order.
// Reset clears only the stage valid bits; the data registers keep whatever they hold.
// When the result sink stalls, each full stage holds its word and the stall backs up
// combinationally through every full stage, so no word is dropped or repeated.
module nim_product_multiplier_top (
  input logic       clk,
  input logic       rst,
  npm_in_if.sink    operands,
  npm_out_if.source result
);
  import npm_pkg::*;

  logic        s1_valid;
  logic        s1_ready;
  row_word_t   s1_word;
  logic        s2_valid;
  logic        s2_ready;
  group_word_t s2_word;

  npm_row_stage u_row (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .left      (operands.left_operand),
    .right     (operands.right_operand),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_word  (s1_word)
  );

  npm_group_stage u_group (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_word   (s1_word),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_word  (s2_word)
  );

  npm_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_word   (s2_word),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .product   (result.product)
  );

  // A zero left factor must leave every group sum at zero.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ready && (s1_word.left == '0) |=> (s2_word == '0))
    else $error("nonzero group sums for a zero left factor");

  // A new result can only come from a full group stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(s2_valid))
    else $error("result valid without a word in the group stage");

  // A blocked group stage keeps its word until the sum stage takes it.
  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_ready |=> s2_valid && $stable(s2_word))
    else $error("group stage word lost during a stall");

endmodule
